### design/http_request_head_parser_assert.svh
// Assertion macros for the request head parser.
`ifndef HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define HRHP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define HRHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define HRHP_ASSERT(label, clk, rst, prop)

`define HRHP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/hrhp_pkg.sv
`default_nettype none

package hrhp_pkg;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_METHOD  = 3'd1;
  localparam logic [2:0] KIND_URL     = 3'd2;
  localparam logic [2:0] KIND_VERSION = 3'd3;
  localparam logic [2:0] KIND_KEY     = 3'd4;
  localparam logic [2:0] KIND_VALUE   = 3'd5;
  localparam logic [2:0] KIND_DONE    = 3'd6;

  localparam logic [1:0] REG_MAX_HEADERS           = 2'd0;
  localparam logic [1:0] REG_DECODE_PERCENT        = 2'd1;
  localparam logic [1:0] REG_SEPARATOR_NEEDS_SPACE = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       is_get;
    logic [7:0] header_number;
    logic       header_overflow;
    logic       malformed;
  } result_t;

  // Results caused by one input word, oldest in slot 0.
  typedef struct packed {
    logic [1:0]       cnt;
    result_t [2:0]    res;
  } bundle_t;

endpackage

`default_nettype wire

### design/http_request_head_parser.sv
// HTTP request head parser.
// Input: one raw request byte per word on in_byte, taken when push is high
// and full is low. Results: one tagged word per pop, shown while empty is
// low; a byte causes zero to three results, and last marks its final one.
// Configuration: APB writes to max_headers (0x0), decode_percent (0x4) and
// separator_needs_space (0x8). The user must make them only while the block
// is idle; the block does not enforce this. A byte's results go through the
// queue into the output register. Throughput: one byte per cycle while each
// byte yields at most one result and pop stays high; the output side moves
// one result per cycle while pop is high. Each byte with results takes one
// of QUEUE_DEPTH queue entries, and full rises when the queue fills.
// Reset: parser state, queue and output valid flag clear; registers return
// to 12, 1 and 1. When the receiver stalls, the current result holds, the
// queue fills and full then stops the input.
`default_nettype none

module http_request_head_parser
  import hrhp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  in_byte,
  input  wire logic        push,
  output logic             full,
  output logic [2:0]       field_kind,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             field_end,
  output logic             is_get,
  output logic [7:0]       header_number,
  output logic             header_overflow,
  output logic             malformed,
  output logic             last,
  output logic             empty,
  input  wire logic        pop,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  `include "http_request_head_parser_assert.svh"

  logic [7:0] max_headers;
  logic       decode_percent;
  logic       separator_needs_space;
  logic       accept;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  bundle_t    front_bundle;
  bundle_t    q_head;
  result_t    result;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign full    = q_full;
  assign accept  = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_headers           <= 8'd12;
      decode_percent        <= 1'b1;
      separator_needs_space <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_MAX_HEADERS:           max_headers           <= pwdata[7:0];
        REG_DECODE_PERCENT:        decode_percent        <= pwdata[0];
        REG_SEPARATOR_NEEDS_SPACE: separator_needs_space <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_HEADERS:           prdata = {24'd0, max_headers};
      REG_DECODE_PERCENT:        prdata = {31'd0, decode_percent};
      REG_SEPARATOR_NEEDS_SPACE: prdata = {31'd0, separator_needs_space};
      default:                   prdata = 32'd0;
    endcase
  end

  hrhp_front u_front (
    .clk                   (clk),
    .rst                   (rst),
    .accept                (accept),
    .in_byte               (in_byte),
    .max_headers           (max_headers),
    .decode_percent        (decode_percent),
    .separator_needs_space (separator_needs_space),
    .bundle                (front_bundle)
  );

  hrhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept && front_bundle.cnt != 2'd0),
    .wdata (front_bundle),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  hrhp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_empty (q_empty),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result),
    .last       (last)
  );

  assign field_kind      = result.kind;
  assign out_byte        = result.out_byte;
  assign byte_valid      = result.byte_valid;
  assign field_end       = result.field_end;
  assign is_get          = result.is_get;
  assign header_number   = result.header_number;
  assign header_overflow = result.header_overflow;
  assign malformed       = result.malformed;

  `HRHP_ASSERT_NEXT(a_burst_continues, clk, rst, pop && !empty && !last, !empty)
  `HRHP_ASSERT(a_none_is_malformed, clk, rst,
    (!empty && field_kind == KIND_NONE) |-> (malformed && !byte_valid))
  `HRHP_ASSERT(a_byte_or_end, clk, rst, !empty |-> !(byte_valid && field_end))
  `HRHP_ASSERT(a_get_on_method_end, clk, rst,
    (!empty && is_get) |-> (field_kind == KIND_METHOD && field_end))

endmodule

`default_nettype wire

### design/hrhp_front.sv
`default_nettype none

module hrhp_front
  import hrhp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic [7:0] max_headers,
  input  wire logic       decode_percent,
  input  wire logic       separator_needs_space,
  output bundle_t         bundle
);

  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [2:0] MPOS_FULL  = 3'd3;
  localparam logic [2:0] MPOS_FAIL  = 3'd4;
  localparam logic [7:0] COUNT_MAX  = 8'd255;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_URL,
    PH_VERSION,
    PH_KEY,
    PH_VALUE
  } phase_t;

  phase_t     phase, phase_next;
  logic       cr_pending, cr_pending_next;
  logic [1:0] percent_stage, percent_stage_next;
  logic [7:0] first_hex_char, first_hex_char_next;
  logic       colon_seen, colon_seen_next;
  logic       line_nonempty, line_nonempty_next;
  logic [2:0] method_match_pos, method_match_pos_next;
  logic [7:0] header_count, header_count_next;

  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] get_char(logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h67;
      3'd1:    r = 8'h65;
      3'd2:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic bundle_t add(bundle_t b, logic [2:0] kind, logic [7:0] data,
                                  logic valid, logic fend, logic get, logic bad);
    result_t r;
    r = '0;
    r.kind       = kind;
    r.out_byte   = valid ? data : 8'd0;
    r.byte_valid = valid;
    r.field_end  = fend;
    r.is_get     = get;
    r.malformed  = bad;
    if (b.cnt != 2'd3) begin
      b.res[b.cnt] = r;
      b.cnt = b.cnt + 2'd1;
    end
    return b;
  endfunction

  function automatic bundle_t flush(bundle_t b, logic [1:0] pst, logic [7:0] hex1,
                                    logic colon);
    bundle_t o;
    o = b;
    if (pst == 2'd1) begin
      o = add(o, KIND_URL, CH_PERCENT, 1'b1, 1'b0, 1'b0, 1'b0);
    end else if (pst == 2'd2) begin
      o = add(o, KIND_URL, CH_PERCENT, 1'b1, 1'b0, 1'b0, 1'b0);
      o = add(o, KIND_URL, hex1, 1'b1, 1'b0, 1'b0, 1'b0);
    end
    if (colon) begin
      o = add(o, KIND_KEY, CH_COLON, 1'b1, 1'b0, 1'b0, 1'b0);
    end
    return o;
  endfunction

  always_comb begin
    bundle_t    b;
    logic [4:0] hx_c;
    logic [4:0] hx_1;
    logic       plain;
    logic [7:0] low;
    b     = '0;
    hx_c  = hex_decode(in_byte);
    hx_1  = hex_decode(first_hex_char);
    plain = 1'b1;
    low   = (in_byte >= 8'h41 && in_byte <= 8'h5a) ? in_byte + 8'd32 : in_byte;
    phase_next            = phase;
    cr_pending_next       = cr_pending;
    percent_stage_next    = percent_stage;
    first_hex_char_next   = first_hex_char;
    colon_seen_next       = colon_seen;
    line_nonempty_next    = line_nonempty;
    method_match_pos_next = method_match_pos;
    header_count_next     = header_count;

    if (in_byte == CH_CR) begin
      if (cr_pending) begin
        b = add(b, KIND_NONE, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      b = flush(b, percent_stage, first_hex_char, colon_seen);
      percent_stage_next = 2'd0;
      colon_seen_next    = 1'b0;
      cr_pending_next    = 1'b1;
    end else if (in_byte == CH_LF) begin
      cr_pending_next    = 1'b0;
      b = flush(b, percent_stage, first_hex_char, colon_seen);
      percent_stage_next = 2'd0;
      colon_seen_next    = 1'b0;
      case (phase)
        PH_URL: begin
          b = add(b, KIND_URL, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
          phase_next = PH_KEY;
        end
        PH_VERSION: begin
          b = add(b, KIND_VERSION, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
          phase_next = PH_KEY;
        end
        PH_KEY: begin
          b = add(b, KIND_DONE, 8'd0, 1'b0, 1'b1, 1'b0, line_nonempty);
          phase_next            = PH_METHOD;
          header_count_next     = 8'd0;
          method_match_pos_next = 3'd0;
        end
        PH_VALUE: begin
          b = add(b, KIND_VALUE, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
          if (header_count != COUNT_MAX) begin
            header_count_next = header_count + 8'd1;
          end
          phase_next = PH_KEY;
        end
        default: begin
          if (line_nonempty) begin
            b = add(b, KIND_METHOD, 8'd0, 1'b0, 1'b1,
                    method_match_pos == MPOS_FULL, 1'b1);
            phase_next = PH_KEY;
          end
          method_match_pos_next = 3'd0;
        end
      endcase
      line_nonempty_next = 1'b0;
    end else begin
      if (cr_pending) begin
        b = add(b, KIND_NONE, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        cr_pending_next = 1'b0;
      end
      line_nonempty_next = 1'b1;
      case (phase)
        PH_URL: begin
          if (percent_stage == 2'd1) begin
            if (hx_c[4]) begin
              first_hex_char_next = in_byte;
              percent_stage_next  = 2'd2;
              plain = 1'b0;
            end else begin
              b = add(b, KIND_URL, CH_PERCENT, 1'b1, 1'b0, 1'b0, 1'b0);
              percent_stage_next = 2'd0;
            end
          end else if (percent_stage == 2'd2) begin
            if (hx_c[4]) begin
              b = add(b, KIND_URL, {hx_1[3:0], hx_c[3:0]}, 1'b1, 1'b0, 1'b0, 1'b0);
              percent_stage_next = 2'd0;
              plain = 1'b0;
            end else begin
              b = add(b, KIND_URL, CH_PERCENT, 1'b1, 1'b0, 1'b0, 1'b0);
              b = add(b, KIND_URL, first_hex_char, 1'b1, 1'b0, 1'b0, 1'b0);
              percent_stage_next = 2'd0;
            end
          end
          if (plain) begin
            if (in_byte == CH_SPACE) begin
              b = add(b, KIND_URL, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
              phase_next = PH_VERSION;
            end else if (in_byte == CH_PERCENT && decode_percent) begin
              percent_stage_next = 2'd1;
            end else begin
              b = add(b, KIND_URL, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
            end
          end
        end
        PH_VERSION: begin
          b = add(b, KIND_VERSION, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
        end
        PH_KEY: begin
          if (colon_seen) begin
            colon_seen_next = 1'b0;
            if (in_byte == CH_SPACE) begin
              b = add(b, KIND_KEY, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
              phase_next = PH_VALUE;
              plain = 1'b0;
            end else begin
              b = add(b, KIND_KEY, CH_COLON, 1'b1, 1'b0, 1'b0, 1'b0);
            end
          end
          if (plain) begin
            if (in_byte == CH_COLON) begin
              if (separator_needs_space) begin
                colon_seen_next = 1'b1;
              end else begin
                b = add(b, KIND_KEY, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
                phase_next = PH_VALUE;
              end
            end else begin
              b = add(b, KIND_KEY, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
            end
          end
        end
        PH_VALUE: begin
          b = add(b, KIND_VALUE, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
        end
        default: begin
          if (in_byte == CH_SPACE) begin
            b = add(b, KIND_METHOD, 8'd0, 1'b0, 1'b1,
                    method_match_pos == MPOS_FULL, 1'b0);
            method_match_pos_next = 3'd0;
            phase_next = PH_URL;
          end else begin
            b = add(b, KIND_METHOD, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
            if (method_match_pos < MPOS_FULL && low == get_char(method_match_pos)) begin
              method_match_pos_next = method_match_pos + 3'd1;
            end else begin
              method_match_pos_next = MPOS_FAIL;
            end
          end
        end
      endcase
    end

    for (int i = 0; i < 3; i++) begin
      if (b.res[i].kind == KIND_KEY || b.res[i].kind == KIND_VALUE) begin
        b.res[i].header_number   = header_count;
        b.res[i].header_overflow = header_count >= max_headers;
      end else if (b.res[i].kind == KIND_DONE) begin
        b.res[i].header_number   = header_count;
        b.res[i].header_overflow = header_count > max_headers;
      end
    end
    bundle = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_METHOD;
      cr_pending       <= 1'b0;
      percent_stage    <= 2'd0;
      first_hex_char   <= 8'd0;
      colon_seen       <= 1'b0;
      line_nonempty    <= 1'b0;
      method_match_pos <= 3'd0;
      header_count     <= 8'd0;
    end else if (accept) begin
      phase            <= phase_next;
      cr_pending       <= cr_pending_next;
      percent_stage    <= percent_stage_next;
      first_hex_char   <= first_hex_char_next;
      colon_seen       <= colon_seen_next;
      line_nonempty    <= line_nonempty_next;
      method_match_pos <= method_match_pos_next;
      header_count     <= header_count_next;
    end
  end

endmodule

`default_nettype wire

### design/hrhp_queue.sv
`default_nettype none

module hrhp_queue
  import hrhp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t wdata,
  input  wire logic    pop,
  output bundle_t      rdata,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  bundle_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == LAST_ADDR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == LAST_ADDR) ? '0 : rd_ptr + AW'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + CW'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### design/hrhp_back.sv
`default_nettype none

module hrhp_back
  import hrhp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t head,
  input  wire logic    head_empty,
  output logic         head_pop,
  input  wire logic    pop,
  output logic         empty,
  output result_t      result,
  output logic         last
);

  logic [1:0] idx;
  logic       ovalid;
  logic       load;
  logic       is_last;

  assign load     = !head_empty && (!ovalid || pop);
  assign is_last  = (idx == head.cnt - 2'd1);
  assign head_pop = load && is_last;
  assign empty    = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= 2'd0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= is_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= head.res[idx];
      last   <= is_last;
    end
  end

endmodule

`default_nettype wire

### test/http_request_head_parser_tb.sv
module http_request_head_parser_tb;
  import hrhp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 6;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [23:0] GET_TEXT = "get";

  typedef enum logic [2:0] {PH_METHOD, PH_URL, PH_VERSION, PH_KEY, PH_VALUE} phase_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } parsed_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  in_byte = 8'h00;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  field_kind;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        field_end;
  logic        is_get;
  logic [7:0]  header_number;
  logic        header_overflow;
  logic        malformed;
  logic        last;
  logic        empty;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // parser state as seen by the checker
  phase_t     phase = PH_METHOD;
  logic       cr_pending = 1'b0;
  logic [1:0] pct_stage = 2'd0;
  logic [7:0] hex_first = 8'h00;
  logic       colon_held = 1'b0;
  logic       line_has_data = 1'b0;
  logic [2:0] get_pos = 3'd0;
  logic [7:0] hdr_count = 8'd0;
  logic [7:0] cfg_max_hdr = 8'd12;
  logic       cfg_decode = 1'b1;
  logic       cfg_need_space = 1'b1;

  parsed_word_t step_words [3];
  int           step_count;
  parsed_word_t awaited_words [$];
  parsed_word_t head_word;
  logic [7:0]   head_bytes [$];

  int error_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int noise_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  http_request_head_parser DUT (
    .clk(clk),
    .rst(rst),
    .in_byte(in_byte),
    .push(push),
    .full(full),
    .field_kind(field_kind),
    .out_byte(out_byte),
    .byte_valid(byte_valid),
    .field_end(field_end),
    .is_get(is_get),
    .header_number(header_number),
    .header_overflow(header_overflow),
    .malformed(malformed),
    .last(last),
    .empty(empty),
    .pop(pop),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c <= "9") return 4'(c - "0");
    if (c >= "a") return 4'(c - "a" + 8'd10);
    return 4'(c - "A" + 8'd10);
  endfunction

  function automatic void add_res(input logic [2:0] kind, input logic [7:0] b, input bit valid,
                                  input bit fend, input bit get, input bit bad);
    parsed_word_t w;
    if (step_count >= 3) return;
    w.res.kind = kind;
    w.res.out_byte = valid ? b : 8'h00;
    w.res.byte_valid = valid;
    w.res.field_end = fend;
    w.res.is_get = get;
    w.res.header_number = 8'd0;
    w.res.header_overflow = 1'b0;
    w.res.malformed = bad;
    w.last = 1'b0;
    if (kind == KIND_KEY || kind == KIND_VALUE) begin
      w.res.header_number = hdr_count;
      w.res.header_overflow = hdr_count >= cfg_max_hdr;
    end else if (kind == KIND_DONE) begin
      w.res.header_number = hdr_count;
      w.res.header_overflow = hdr_count > cfg_max_hdr;
    end
    step_words[step_count] = w;
    step_count++;
  endfunction

  function automatic void add_byte(input logic [2:0] kind, input logic [7:0] b);
    add_res(kind, b, 1'b1, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void add_end(input logic [2:0] kind, input bit get, input bit bad);
    add_res(kind, 8'h00, 1'b0, 1'b1, get, bad);
  endfunction

  function automatic void flush_held();
    if (pct_stage == 2'd1) begin
      add_byte(KIND_URL, CH_PCT);
    end else if (pct_stage == 2'd2) begin
      add_byte(KIND_URL, CH_PCT);
      add_byte(KIND_URL, hex_first);
    end
    pct_stage = 2'd0;
    if (colon_held) add_byte(KIND_KEY, CH_COLON);
    colon_held = 1'b0;
  endfunction

  function automatic void parse_request_byte(input logic [7:0] c);
    logic [7:0] low;
    bit taken;
    int i;
    step_count = 0;
    taken = 1'b0;
    if (c == CH_CR) begin
      if (cr_pending) add_res(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      flush_held();
      cr_pending = 1'b1;
    end else if (c == CH_LF) begin
      cr_pending = 1'b0;
      flush_held();
      case (phase)
        PH_URL: begin
          add_end(KIND_URL, 1'b0, 1'b1);
          phase = PH_KEY;
        end
        PH_VERSION: begin
          add_end(KIND_VERSION, 1'b0, 1'b0);
          phase = PH_KEY;
        end
        PH_KEY: begin
          add_end(KIND_DONE, 1'b0, line_has_data);
          phase = PH_METHOD;
          hdr_count = 8'd0;
          get_pos = 3'd0;
        end
        PH_VALUE: begin
          add_end(KIND_VALUE, 1'b0, 1'b0);
          if (hdr_count != 8'hff) hdr_count++;
          phase = PH_KEY;
        end
        default: begin
          if (line_has_data) begin
            add_end(KIND_METHOD, get_pos == 3'd3, 1'b1);
            phase = PH_KEY;
          end
          get_pos = 3'd0;
        end
      endcase
      line_has_data = 1'b0;
    end else begin
      if (cr_pending) begin
        add_res(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        cr_pending = 1'b0;
      end
      line_has_data = 1'b1;
      case (phase)
        PH_URL: begin
          if (pct_stage == 2'd1) begin
            if (is_hex(c)) begin
              hex_first = c;
              pct_stage = 2'd2;
              taken = 1'b1;
            end else begin
              add_byte(KIND_URL, CH_PCT);
              pct_stage = 2'd0;
            end
          end else if (pct_stage == 2'd2) begin
            if (is_hex(c)) begin
              add_byte(KIND_URL, {hex_nibble(hex_first), hex_nibble(c)});
              pct_stage = 2'd0;
              taken = 1'b1;
            end else begin
              add_byte(KIND_URL, CH_PCT);
              add_byte(KIND_URL, hex_first);
              pct_stage = 2'd0;
            end
          end
          if (!taken) begin
            if (c == CH_SP) begin
              add_end(KIND_URL, 1'b0, 1'b0);
              phase = PH_VERSION;
            end else if (c == CH_PCT && cfg_decode) begin
              pct_stage = 2'd1;
            end else begin
              add_byte(KIND_URL, c);
            end
          end
        end
        PH_VERSION: add_byte(KIND_VERSION, c);
        PH_KEY: begin
          if (colon_held) begin
            colon_held = 1'b0;
            if (c == CH_SP) begin
              add_end(KIND_KEY, 1'b0, 1'b0);
              phase = PH_VALUE;
              taken = 1'b1;
            end else begin
              add_byte(KIND_KEY, CH_COLON);
            end
          end
          if (!taken) begin
            if (c == CH_COLON) begin
              if (cfg_need_space) begin
                colon_held = 1'b1;
              end else begin
                add_end(KIND_KEY, 1'b0, 1'b0);
                phase = PH_VALUE;
              end
            end else begin
              add_byte(KIND_KEY, c);
            end
          end
        end
        PH_VALUE: add_byte(KIND_VALUE, c);
        default: begin
          if (c == CH_SP) begin
            add_end(KIND_METHOD, get_pos == 3'd3, 1'b0);
            get_pos = 3'd0;
            phase = PH_URL;
          end else begin
            low = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
            add_byte(KIND_METHOD, c);
            if (get_pos < 3'd3 && low == GET_TEXT[23 - 8 * get_pos -: 8]) get_pos++;
            else get_pos = 3'd4;
          end
        end
      endcase
    end
    for (i = 0; i < step_count; i++) begin
      step_words[i].last = (i == step_count - 1);
      awaited_words.push_back(step_words[i]);
    end
  endfunction

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_error($sformatf("%s got %02h want %02h", name, got, want));
  endtask

  // check result words; pick pop for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_words.size() == 0) begin
          report_error($sformatf("unexpected word kind %0d byte %02h", field_kind, out_byte));
        end else begin
          head_word = awaited_words.pop_front();
          check_field("field_kind", 8'(field_kind), 8'(head_word.res.kind));
          check_field("out_byte", out_byte, head_word.res.out_byte);
          check_field("byte_valid", 8'(byte_valid), 8'(head_word.res.byte_valid));
          check_field("field_end", 8'(field_end), 8'(head_word.res.field_end));
          check_field("is_get", 8'(is_get), 8'(head_word.res.is_get));
          check_field("header_number", header_number, head_word.res.header_number);
          check_field("header_overflow", 8'(header_overflow),
                      8'(head_word.res.header_overflow));
          check_field("malformed", 8'(malformed), 8'(head_word.res.malformed));
          check_field("last", 8'(last), 8'(head_word.last));
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    parse_request_byte(b);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_head();
    foreach (head_bytes[i]) send_byte(head_bytes[i]);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MAX_HEADERS: cfg_max_hdr = val[7:0];
      REG_DECODE_PERCENT: cfg_decode = val[0];
      REG_SEPARATOR_NEEDS_SPACE: cfg_need_space = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] max_h, input bit dec, input bit sep);
    drain_results();
    write_reg(REG_MAX_HEADERS, {24'h0, max_h});
    write_reg(REG_DECODE_PERCENT, {31'h0, dec});
    write_reg(REG_SEPARATOR_NEEDS_SPACE, {31'h0, sep});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void put(input logic [7:0] c);
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    if ($urandom_range(99) < noise_pct) head_bytes.push_back(junk);
    head_bytes.push_back(c);
  endfunction

  function automatic void put_eol();
    case ($urandom_range(7))
      0: begin
        put(CH_CR);
        put(CH_CR);
      end
      1, 2, 3: put(CH_CR);
      default: ;
    endcase
    put(CH_LF);
  endfunction

  function automatic logic [7:0] letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(25));
    if ($urandom_range(1)) c = c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CH_CR || c == CH_LF || c == CH_SP) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(15));
    if (v < 10) return "0" + v;
    return ($urandom_range(1) ? "a" : "A") + v - 8'd10;
  endfunction

  function automatic void build_head();
    int spaces, n, i, k, hdrs;
    logic [7:0] c;
    head_bytes.delete();
    if ($urandom_range(4) == 0) put_eol();
    spaces = ($urandom_range(9) == 0) ? $urandom_range(1) : 2;
    if ($urandom_range(2) == 0) begin
      for (i = 0; i < 3; i++) begin
        c = GET_TEXT[23 - 8 * i -: 8];
        if ($urandom_range(1)) c = c - 8'h20;
        put(c);
      end
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) put(letter());
    end
    if (spaces > 0) begin
      put(CH_SP);
      put(CH_SLASH);
      n = $urandom_range(4);
      repeat (n) begin
        case ($urandom_range(5))
          0: begin
            put(CH_PCT);
            put(hex_char());
            put(hex_char());
          end
          1: begin
            put(CH_PCT);
            if ($urandom_range(1)) put(hex_char());
            put(field_char());
          end
          2: put(field_char());
          default: put(letter());
        endcase
      end
      if ($urandom_range(5) == 0) begin
        put(CH_PCT);
        if ($urandom_range(1)) put(hex_char());
      end
      if (spaces > 1) begin
        put(CH_SP);
        n = $urandom_range(1, 4);
        repeat (n) put($urandom_range(1) ? letter() : field_char());
      end
    end
    put_eol();
    hdrs = ($urandom_range(7) == 0) ? $urandom_range(3, 5) : $urandom_range(1);
    for (k = 0; k < hdrs; k++) begin
      n = $urandom_range(3);
      repeat (n) put(letter());
      put(CH_COLON);
      if ($urandom_range(5) != 0) put(CH_SP);
      n = $urandom_range(5);
      repeat (n) put(($urandom_range(4) == 0) ? CH_SP : field_char());
      put_eol();
    end
    if ($urandom_range(5) == 0) begin
      put(letter());
      if ($urandom_range(1)) put(CH_COLON);
    end
    put_eol();
  endfunction

  task automatic test_request_line();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_text("\nGeT %41%z%4\015\015\n");
  endtask

  task automatic test_header_line();
    send_text("k:");
    send_byte(8'hff);
    send_text(": ");
    send_byte(8'h00);
    send_text("\nx:\n");
  endtask

  task automatic test_config_switch();
    set_config(8'd0, 1'b1, 1'b1);
    send_text("GET /%4");
    set_config(8'd0, 1'b0, 1'b0);
    send_text("1 v\nk:v\n\nQ\n\n");
  endtask

  task automatic test_header_limit();
    set_config(8'd2, 1'b1, 1'b0);
    send_text("G / V\n");
    repeat (4) send_text(":\n");
    send_text("\n");
  endtask

  task automatic test_random_heads(input int tx_pct, input int rx_pct, input logic [7:0] max_h,
                                   input bit dec, input bit sep);
    int sent;
    set_config(max_h, dec, sep);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    noise_pct = 3;
    sent = 0;
    while (sent < 16) begin
      build_head();
      send_head();
      sent += head_bytes.size();
    end
  endtask

  task automatic test_backpressure();
    set_config(8'd3, 1'b1, 1'b1);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    noise_pct = 0;
    do build_head(); while (head_bytes.size() < 12);
    hold_asks++;
    send_head();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_request_line();
    test_header_line();
    test_config_switch();
    test_header_limit();
    test_random_heads(0, 0, 8'd12, 1'b1, 1'b1);
    test_random_heads(82, 0, 8'd1, 1'b0, 1'b0);
    test_random_heads(0, 82, 8'd2, 1'b1, 1'b0);
    test_random_heads(24, 24, 8'($urandom_range(255)), 1'b0, 1'b1);
    test_backpressure();
    rx_stall_pct = 0;
    drain_results();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
